// ===== sv/tcw_pkg.sv =====
// Shared constants, command/status types and address helper for the text console writer.
// No dependencies; imported by every module of the block.
`default_nettype none

package tcw_pkg;

    localparam int ROWS   = 25;
    localparam int COLS   = 80;
    localparam int CELLS  = ROWS * COLS;
    localparam int ADDR_W = $clog2(CELLS);

    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int OP_W   = 3;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CNT_W  = 11;

    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'd15;

    localparam logic [OP_W-1:0] OP_PUT      = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE   = 3'd1;
    localparam logic [OP_W-1:0] OP_CLEAR    = 3'd2;
    localparam logic [OP_W-1:0] OP_RECOLOUR = 3'd3;
    localparam logic [OP_W-1:0] OP_READ     = 3'd4;

    localparam int ACT_W = 4;
    localparam logic [ACT_W-1:0] ACT_NONE     = 4'd0;
    localparam logic [ACT_W-1:0] ACT_INIT     = 4'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR    = 4'd2;
    localparam logic [ACT_W-1:0] ACT_RECOLOUR = 4'd3;
    localparam logic [ACT_W-1:0] ACT_SHIFT    = 4'd4;
    localparam logic [ACT_W-1:0] ACT_READ     = 4'd5;
    localparam logic [ACT_W-1:0] ACT_PUT      = 4'd6;
    localparam logic [ACT_W-1:0] ACT_REMOVE   = 4'd7;
    localparam logic [ACT_W-1:0] ACT_NEWLINE  = 4'd8;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic             capture;
        logic             home;
        logic             load_out;
    } tcw_cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic shift_last;
        logic rem_done;
        logic wrap_pending;
        logic last_row;
        logic is_nl;
        logic out_free;
    } tcw_status_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                     input logic [COL_W-1:0] col);
        cell_addr = ADDR_W'(int'(row) * COLS + int'(col));
    endfunction

endpackage

`default_nettype wire

// ===== sv/tcw_datapath.sv =====
// Datapath: cursor, sweep counter, captured beat, cell store (char and attr arrays),
// colour register and result register. Depends on tcw_pkg.
`default_nettype none

module tcw_datapath
    import tcw_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire tcw_cmd_t          cmd,
    output tcw_status_t            status,
    input  wire logic [OP_W-1:0]   s_op,
    input  wire logic [CHAR_W-1:0] s_char_code,
    input  wire logic [CNT_W-1:0]  s_count,
    input  wire logic [ATTR_W-1:0] s_fill_colour,
    input  wire logic [ROW_W-1:0]  s_cell_row,
    input  wire logic [COL_W-1:0]  s_cell_col,
    input  wire logic              cfg_wr_en,
    input  wire logic [ATTR_W-1:0] cfg_wr_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [ROW_W-1:0]       m_cursor_row,
    output logic [COL_W-1:0]       m_cursor_col,
    output logic [CHAR_W-1:0]      m_read_char,
    output logic [ATTR_W-1:0]      m_read_attr
);

    logic [CHAR_W-1:0] char_mem [CELLS];
    logic [ATTR_W-1:0] attr_mem [CELLS];

    logic [OP_W-1:0]   op_reg;
    logic [CHAR_W-1:0] char_reg;
    logic [ATTR_W-1:0] fill_reg;
    logic [ROW_W-1:0]  rrow_reg;
    logic [COL_W-1:0]  rcol_reg;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [ADDR_W-1:0] k_reg, k_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ATTR_W-1:0] colour_reg;
    logic [CHAR_W-1:0] rd_char_reg;
    logic [ATTR_W-1:0] rd_attr_reg;
    logic              m_valid_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic [CHAR_W-1:0] out_char_reg;
    logic [ATTR_W-1:0] out_attr_reg;

    logic              wrap;
    logic              in_range;
    logic [ROW_W-1:0]  back_row, eff_row;
    logic [COL_W-1:0]  back_col, eff_col;
    logic              char_we, attr_we, rd_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [CHAR_W-1:0] char_wd;
    logic [ATTR_W-1:0] attr_wd;

    assign wrap     = (col_reg >= COL_W'(COLS));
    assign in_range = (rrow_reg < ROW_W'(ROWS)) && (rcol_reg < COL_W'(COLS));

    always_comb begin
        if (col_reg == '0) begin
            back_row = row_reg - ROW_W'(1);
            back_col = COL_W'(COLS - 1);
        end else begin
            back_row = row_reg;
            back_col = col_reg - COL_W'(1);
        end
        if (wrap) begin
            eff_row = row_reg + ROW_W'(1);
            eff_col = '0;
        end else begin
            eff_row = row_reg;
            eff_col = col_reg;
        end
    end

    always_comb begin
        char_we  = 1'b0;
        attr_we  = 1'b0;
        rd_en    = 1'b0;
        wr_addr  = k_reg;
        rd_addr  = k_reg + ADDR_W'(COLS);
        char_wd  = SPACE_CODE;
        attr_wd  = colour_reg;
        k_next   = k_reg;
        rem_next = rem_reg;
        row_next = row_reg;
        col_next = col_reg;
        unique case (cmd.act)
            ACT_INIT: begin
                char_we = 1'b1;
                attr_we = 1'b1;
                attr_wd = RESET_ATTR;
                k_next  = k_reg + ADDR_W'(1);
            end
            ACT_CLEAR: begin
                char_we = 1'b1;
                attr_we = 1'b1;
                k_next  = k_reg + ADDR_W'(1);
            end
            ACT_RECOLOUR: begin
                attr_we = 1'b1;
                attr_wd = fill_reg;
                k_next  = k_reg + ADDR_W'(1);
            end
            ACT_SHIFT: begin
                rd_en   = (k_reg < ADDR_W'(CELLS - COLS));
                char_we = (k_reg != '0);
                attr_we = (k_reg != '0);
                wr_addr = k_reg - ADDR_W'(1);
                char_wd = rd_char_reg;
                attr_wd = rd_attr_reg;
                if (k_reg != ADDR_W'(CELLS - COLS)) begin
                    k_next = k_reg + ADDR_W'(1);
                end
            end
            ACT_READ: begin
                rd_en   = in_range;
                rd_addr = cell_addr(rrow_reg, rcol_reg);
            end
            ACT_PUT: begin
                char_we  = 1'b1;
                attr_we  = 1'b1;
                wr_addr  = cell_addr(eff_row, eff_col);
                char_wd  = char_reg;
                row_next = eff_row;
                col_next = eff_col + COL_W'(1);
            end
            ACT_REMOVE: begin
                char_we  = 1'b1;
                attr_we  = 1'b1;
                wr_addr  = cell_addr(back_row, back_col);
                row_next = back_row;
                col_next = back_col;
                rem_next = rem_reg - CNT_W'(1);
            end
            ACT_NEWLINE: begin
                col_next = '0;
                k_next   = '0;
                if (row_reg != ROW_W'(ROWS - 1)) begin
                    row_next = row_reg + ROW_W'(1);
                end
            end
            default: begin
            end
        endcase
        if (cmd.home) begin
            row_next = '0;
            col_next = '0;
        end
        if (cmd.capture) begin
            k_next   = '0;
            rem_next = s_count;
        end
    end

    always_ff @(posedge aclk) begin
        if (char_we) begin
            char_mem[wr_addr] <= char_wd;
        end
        if (attr_we) begin
            attr_mem[wr_addr] <= attr_wd;
        end
        if (rd_en) begin
            rd_char_reg <= char_mem[rd_addr];
            rd_attr_reg <= attr_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg   <= s_op;
            char_reg <= s_char_code;
            fill_reg <= s_fill_colour;
            rrow_reg <= s_cell_row;
            rcol_reg <= s_cell_col;
        end
        rem_reg <= rem_next;
        if (cmd.load_out) begin
            out_row_reg <= row_next;
            out_col_reg <= col_next;
            if ((op_reg == OP_READ) && in_range) begin
                out_char_reg <= rd_char_reg;
                out_attr_reg <= rd_attr_reg;
            end else begin
                out_char_reg <= '0;
                out_attr_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg       <= '0;
            row_reg     <= '0;
            col_reg     <= '0;
            colour_reg  <= RESET_ATTR;
            m_valid_reg <= 1'b0;
        end else begin
            k_reg   <= k_next;
            row_reg <= row_next;
            col_reg <= col_next;
            if (cfg_wr_en) begin
                colour_reg <= cfg_wr_data;
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign status.sweep_last   = (k_reg == ADDR_W'(CELLS - 1));
    assign status.shift_last   = (k_reg == ADDR_W'(CELLS - COLS));
    assign status.rem_done     = (rem_reg == '0) || ((row_reg == '0) && (col_reg == '0));
    assign status.wrap_pending = wrap;
    assign status.last_row     = (row_reg == ROW_W'(ROWS - 1));
    assign status.is_nl        = (char_reg == NEWLINE_CODE);
    assign status.out_free     = !m_valid_reg || m_ready;

    assign m_valid      = m_valid_reg;
    assign m_cursor_row = out_row_reg;
    assign m_cursor_col = out_col_reg;
    assign m_read_char  = out_char_reg;
    assign m_read_attr  = out_attr_reg;

endmodule

`default_nettype wire

// ===== sv/tcw_ctrl.sv =====
// Controller state machine: sequences the reset sweep, put, newline scroll, remove, clear, recolour and read.
// Depends on tcw_pkg; drives the datapath through tcw_cmd_t and reads tcw_status_t.
`default_nettype none

module tcw_ctrl
    import tcw_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic [OP_W-1:0] s_op,
    input  wire tcw_status_t     status,
    output tcw_cmd_t             cmd
);

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_INIT     = 4'd0;
    localparam logic [ST_W-1:0] ST_IDLE     = 4'd1;
    localparam logic [ST_W-1:0] ST_PUT      = 4'd2;
    localparam logic [ST_W-1:0] ST_SHIFT    = 4'd3;
    localparam logic [ST_W-1:0] ST_BLANK    = 4'd4;
    localparam logic [ST_W-1:0] ST_REMOVE   = 4'd5;
    localparam logic [ST_W-1:0] ST_CLEAR    = 4'd6;
    localparam logic [ST_W-1:0] ST_RECOLOUR = 4'd7;
    localparam logic [ST_W-1:0] ST_READ     = 4'd8;
    localparam logic [ST_W-1:0] ST_RESP     = 4'd9;

    logic [ST_W-1:0] state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        cmd.act      = ACT_NONE;
        cmd.capture  = 1'b0;
        cmd.home     = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            ST_INIT: begin
                cmd.act = ACT_INIT;
                if (status.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    unique case (s_op)
                        OP_PUT:      state_next = ST_PUT;
                        OP_REMOVE:   state_next = ST_REMOVE;
                        OP_CLEAR:    state_next = ST_CLEAR;
                        OP_RECOLOUR: state_next = ST_RECOLOUR;
                        OP_READ:     state_next = ST_READ;
                        default:     state_next = ST_RESP;
                    endcase
                end
            end
            ST_PUT: begin
                if (status.is_nl || (status.wrap_pending && status.last_row)) begin
                    cmd.act = ACT_NEWLINE;
                end else begin
                    cmd.act = ACT_PUT;
                end
                if (status.last_row && (status.is_nl || status.wrap_pending)) begin
                    state_next = ST_SHIFT;
                end else if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end else begin
                    state_next = ST_RESP;
                end
            end
            ST_SHIFT: begin
                cmd.act = ACT_SHIFT;
                if (status.shift_last) begin
                    state_next = ST_BLANK;
                end
            end
            ST_BLANK: begin
                cmd.act = ACT_CLEAR;
                if (status.sweep_last) begin
                    state_next = status.is_nl ? ST_RESP : ST_PUT;
                end
            end
            ST_REMOVE: begin
                if (status.wrap_pending || status.rem_done) begin
                    state_next = ST_RESP;
                end else begin
                    cmd.act = ACT_REMOVE;
                end
            end
            ST_CLEAR: begin
                cmd.act  = ACT_CLEAR;
                cmd.home = 1'b1;
                if (status.sweep_last) begin
                    state_next = ST_RESP;
                end
            end
            ST_RECOLOUR: begin
                cmd.act = ACT_RECOLOUR;
                if (status.sweep_last) begin
                    state_next = ST_RESP;
                end
            end
            ST_READ: begin
                cmd.act    = ACT_READ;
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/text_console_writer_top.sv =====
// Text console writer: an 80x25 cell store with cursor, put/remove/clear/recolour/read.
// After reset the block sweeps the store to spaces in attribute 15, one cell per cycle, and
// accepts no beat until done; configuration writes are taken throughout. One item is in
// work at a time: no new beat is taken until the controller is back in IDLE. A newline or
// wrap on the last row scrolls the cell store (one read, one write port): rows are copied up,
// the last row is blanked and a wrapping character is then put. Remove erases up to count
// cells behind the cursor, stopping at home or while a wrap is pending; clear blanks all cells
// and homes, recolour refills all attributes, read fetches one cell, unused codes only report.
// A finished result waits in an output register; a stalled receiver holds the next result.
`default_nettype none

module text_console_writer_top
    import tcw_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [OP_W-1:0]   s_op,
    input  wire logic [CHAR_W-1:0] s_char_code,
    input  wire logic [CNT_W-1:0]  s_count,
    input  wire logic [ATTR_W-1:0] s_fill_colour,
    input  wire logic [ROW_W-1:0]  s_cell_row,
    input  wire logic [COL_W-1:0]  s_cell_col,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [ROW_W-1:0]       m_cursor_row,
    output logic [COL_W-1:0]       m_cursor_col,
    output logic [CHAR_W-1:0]      m_read_char,
    output logic [ATTR_W-1:0]      m_read_attr,
    input  wire logic              cfg_wr_en,
    input  wire logic [ATTR_W-1:0] cfg_wr_data
);

    tcw_cmd_t    cmd;
    tcw_status_t status;

    tcw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .status  (status),
        .cmd     (cmd)
    );

    tcw_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_op          (s_op),
        .s_char_code   (s_char_code),
        .s_count       (s_count),
        .s_fill_colour (s_fill_colour),
        .s_cell_row    (s_cell_row),
        .s_cell_col    (s_cell_col),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_cursor_row  (m_cursor_row),
        .m_cursor_col  (m_cursor_col),
        .m_read_char   (m_read_char),
        .m_read_attr   (m_read_attr)
    );

    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_cursor_row < ROW_W'(ROWS)) && (m_cursor_col <= COL_W'(COLS)))
        else $error("cursor out of range");

    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("beat accepted while another is in work");

    a_result_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result raised without work in progress");

    a_shift_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.act == ACT_SHIFT) |-> status.last_row)
        else $error("scroll started away from the last row");

endmodule

`default_nettype wire
